// ===== hw/rtl/mpf_pkg.sv =====
// Shared constants, types and address helper for the page-mode frame store.
package mpf_pkg;

	localparam int DISPLAY_WIDTH  = 128;
	localparam int DISPLAY_HEIGHT = 64;
	localparam int BYTE_W         = 8;
	localparam int PAGE_COUNT     = (DISPLAY_HEIGHT + 7) / 8;
	localparam int STORE_BYTES    = DISPLAY_WIDTH * PAGE_COUNT;
	localparam int ADDR_W         = $clog2(STORE_BYTES);
	localparam int COL_W          = $clog2(DISPLAY_WIDTH);
	localparam int PG_W           = $clog2(PAGE_COUNT + 1);

	localparam logic [2:0] REQ_SET_PIXEL = 3'd0;
	localparam logic [2:0] REQ_CLR_PIXEL = 3'd1;
	localparam logic [2:0] REQ_RD_PIXEL  = 3'd2;
	localparam logic [2:0] REQ_CLR_ALL   = 3'd3;
	localparam logic [2:0] REQ_SHIFT_UP  = 3'd4;
	localparam logic [2:0] REQ_RD_BYTE   = 3'd5;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PIX,
		ST_SH_PRIME,
		ST_SH_LO,
		ST_SH_WR,
		ST_DONE
	} mpf_state_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [BYTE_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic              valid;
		logic              pixel_value;
		logic [BYTE_W-1:0] byte_value;
	} result_t;

	function automatic logic [ADDR_W-1:0] page_addr(input logic [7:0] page,
		input logic [7:0] col);
		return ADDR_W'(32'(page) * DISPLAY_WIDTH + 32'(col));
	endfunction

endpackage

// ===== hw/rtl/mpf_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module mpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/mpf_ctrl.sv =====
// Request sequencer: pixel read-modify-write, clear sweep and shift sweep.
module mpf_ctrl import mpf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        req_type,
	input  logic [7:0]        x_pos,
	input  logic [7:0]        y_pos,
	input  logic [7:0]        shift_rows,
	output mem_req_t          mem,
	input  logic [BYTE_W-1:0] rd_data,
	output result_t           res,
	input  logic              res_ready
);

	mpf_state_t        state_q, state_d;
	logic [ADDR_W-1:0] addr_q, addr_d;
	logic              resp_q, resp_d;
	logic [2:0]        op_q, op_d;
	logic [2:0]        bit_q, bit_d;
	logic              hit_q, hit_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [PG_W-1:0]   pg_q, pg_d;
	logic [4:0]        q_q, q_d;
	logic [2:0]        s_q, s_d;
	logic [BYTE_W-1:0] lo_q, lo_d;
	logic              hi_ok_s1, hi_ok_d;
	logic              pix_q, pix_d;
	logic [BYTE_W-1:0] byt_q, byt_d;

	logic              in_range;
	logic [7:0]        src, src_n;
	logic [BYTE_W-1:0] hi, mask;
	logic [15:0]       cat;

	assign in_range = ({1'b0, x_pos} < 9'(DISPLAY_WIDTH))
		&& ({1'b0, y_pos} < 9'(DISPLAY_HEIGHT));
	assign src   = 8'(pg_q) + 8'(q_q) + 8'd1;
	assign src_n = src + 8'd1;
	assign hi    = hi_ok_s1 ? rd_data : '0;
	assign cat   = {hi, lo_q} >> s_q;
	assign mask  = BYTE_W'(1) << bit_q;

	always_comb begin
		state_d  = state_q;
		addr_d   = addr_q;
		resp_d   = resp_q;
		op_d     = op_q;
		bit_d    = bit_q;
		hit_d    = hit_q;
		col_d    = col_q;
		pg_d     = pg_q;
		q_d      = q_q;
		s_d      = s_q;
		lo_d     = lo_q;
		hi_ok_d  = hi_ok_s1;
		pix_d    = pix_q;
		byt_d    = byt_q;
		mem      = '0;
		in_stall = 1'b1;
		res.valid       = 1'b0;
		res.pixel_value = pix_q;
		res.byte_value  = byt_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem.we    = 1'b1;
				mem.waddr = addr_q;
				mem.wdata = '0;
				addr_d    = addr_q + ADDR_W'(1);
				if (addr_q == ADDR_W'(STORE_BYTES - 1)) begin
					addr_d  = '0;
					resp_d  = 1'b0;
					state_d = resp_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					op_d  = req_type;
					bit_d = y_pos[2:0];
					hit_d = in_range;
					pix_d = 1'b0;
					byt_d = '0;
					unique case (req_type)
						REQ_SET_PIXEL, REQ_CLR_PIXEL, REQ_RD_PIXEL, REQ_RD_BYTE: begin
							mem.re    = 1'b1;
							mem.raddr = in_range ? page_addr(8'(y_pos[7:3]), x_pos) : '0;
							addr_d    = in_range ? page_addr(8'(y_pos[7:3]), x_pos) : '0;
							state_d   = ST_PIX;
						end
						REQ_CLR_ALL: begin
							resp_d  = 1'b1;
							addr_d  = '0;
							state_d = ST_CLEAR;
						end
						REQ_SHIFT_UP: begin
							if (shift_rows == 8'd0) begin
								state_d = ST_DONE;
							end else if ({1'b0, shift_rows} >= 9'(DISPLAY_HEIGHT)) begin
								resp_d  = 1'b1;
								addr_d  = '0;
								state_d = ST_CLEAR;
							end else begin
								q_d     = shift_rows[7:3];
								s_d     = shift_rows[2:0];
								col_d   = '0;
								state_d = ST_SH_PRIME;
							end
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_PIX: begin
				mem.waddr = addr_q;
				unique case (op_q)
					REQ_SET_PIXEL: begin
						mem.we    = hit_q;
						mem.wdata = rd_data | mask;
					end
					REQ_CLR_PIXEL: begin
						mem.we    = hit_q;
						mem.wdata = rd_data & ~mask;
					end
					REQ_RD_PIXEL: begin
						pix_d = hit_q & rd_data[bit_q];
					end
					REQ_RD_BYTE: begin
						byt_d = hit_q ? rd_data : '0;
					end
					default: begin
					end
				endcase
				state_d = ST_DONE;
			end
			ST_SH_PRIME: begin
				mem.re    = 1'b1;
				mem.raddr = page_addr(8'(q_q), 8'(col_q));
				pg_d      = '0;
				state_d   = ST_SH_LO;
			end
			ST_SH_LO: begin
				lo_d    = rd_data;
				hi_ok_d = src < 8'(PAGE_COUNT);
				if (src < 8'(PAGE_COUNT)) begin
					mem.re    = 1'b1;
					mem.raddr = page_addr(src, 8'(col_q));
				end
				state_d = ST_SH_WR;
			end
			ST_SH_WR: begin
				mem.we    = 1'b1;
				mem.waddr = page_addr(8'(pg_q), 8'(col_q));
				mem.wdata = cat[BYTE_W-1:0];
				lo_d      = hi;
				if (pg_q == PG_W'(PAGE_COUNT - 1)) begin
					if (col_q == COL_W'(DISPLAY_WIDTH - 1)) begin
						state_d = ST_DONE;
					end else begin
						col_d   = col_q + COL_W'(1);
						state_d = ST_SH_PRIME;
					end
				end else begin
					pg_d    = pg_q + PG_W'(1);
					hi_ok_d = src_n < 8'(PAGE_COUNT);
					if (src_n < 8'(PAGE_COUNT)) begin
						mem.re    = 1'b1;
						mem.raddr = page_addr(src_n, 8'(col_q));
					end
				end
			end
			ST_DONE: begin
				res.valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			addr_q  <= '0;
			resp_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			addr_q  <= addr_d;
			resp_q  <= resp_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q     <= op_d;
		bit_q    <= bit_d;
		hit_q    <= hit_d;
		col_q    <= col_d;
		pg_q     <= pg_d;
		q_q      <= q_d;
		s_q      <= s_d;
		lo_q     <= lo_d;
		hi_ok_s1 <= hi_ok_d;
		pix_q    <= pix_d;
		byt_q    <= byt_d;
	end

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !mem.we)
		else $error("store written while idle");

	a_shift_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SH_WR) && mem.we && mem.re |-> mem.waddr != mem.raddr)
		else $error("shift reads a byte it writes in the same cycle");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> mem.we && (mem.wdata == '0))
		else $error("clear sweep writes nonzero data");

	a_pix_write_op: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PIX) && mem.we |-> (op_q == REQ_SET_PIXEL || op_q == REQ_CLR_PIXEL))
		else $error("pixel write for a read request");

	a_result_after_pix: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PIX) |=> res.valid)
		else $error("pixel request did not complete");

endmodule

// ===== hw/rtl/mono_page_framebuffer_unit.sv =====
// Top level of the monochrome page-mode frame store.
//
// Input channel in_valid/in_stall carries one request: req_type, x_pos, y_pos,
// shift_rows. Output channel out_valid/out_stall carries one result per
// request: pixel_value and byte_value (both 0 unless a read hits the store).
// The store is DISPLAY_WIDTH x PAGE_COUNT bytes in one simple dual-port RAM.
// Requests are handled one at a time by the sequencer:
//   set, clear, read pixel and read byte: one RAM read, then a modify/write
//     for set and clear only; the result passes ST_DONE to the output register.
//   clear all, and shift of the full height or more: one zero write to each
//     of the STORE_BYTES bytes (1024 at 128x64).
//   shift of 1 to height-1 rows: a priming read, a second read, then one write
//     per page, one column at a time, pages ascending.
// After arst_n is released a clearing pass zeroes the store; in_stall stays
// high until it ends. A finished result waits in the output register while
// out_stall is high; the sequencer holds its own result until that register
// frees, and then returns to accept requests.
module mono_page_framebuffer_unit import mpf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        req_type,
	input  logic [7:0]        x_pos,
	input  logic [7:0]        y_pos,
	input  logic [7:0]        shift_rows,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              pixel_value,
	output logic [BYTE_W-1:0] byte_value
);

	mem_req_t          mem;
	result_t           res;
	logic [BYTE_W-1:0] rd_data;
	logic              res_ready;
	logic              out_valid_q;
	logic              pixel_q;
	logic [BYTE_W-1:0] byte_q;

	assign res_ready = !out_valid_q || !out_stall;

	mpf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.x_pos      (x_pos),
		.y_pos      (y_pos),
		.shift_rows (shift_rows),
		.mem        (mem),
		.rd_data    (rd_data),
		.res        (res),
		.res_ready  (res_ready)
	);

	mpf_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (STORE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.re    (mem.re),
		.raddr (mem.raddr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			pixel_q <= res.pixel_value;
			byte_q  <= res.byte_value;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_value = pixel_q;
	assign byte_value  = byte_q;

endmodule
